@@ src/grhd_pkg.sv @@
`timescale 1ns / 1ps
// Package for the gear ratio hysteresis detector.
// Shared types and constants; no dependencies.
package grhd_pkg;

  localparam int NUM_GEARS_DEF = 6;
  localparam int GEAR_W = 3;
  localparam int VAL_W = 16;
  localparam int WIN_W = 64;
  localparam int DIV_STEPS = 16;

  // gear codes
  localparam logic [GEAR_W-1:0] GEAR_NEUTRAL = 3'd0;
  localparam logic [GEAR_W-1:0] GEAR_CLUTCH = 3'd7;

  // register indexes, 8-byte stride
  localparam logic [2:0] REG_UNSTABLE = 3'd6;

  // window field positions
  localparam int LOW_IN_LSB = 0;
  localparam int HIGH_IN_LSB = 16;
  localparam int LOW_OUT_LSB = 32;
  localparam int HIGH_OUT_LSB = 48;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

@@ src/grhd_div.sv @@
`timescale 1ns / 1ps
// Restoring serial divider: (num << 16) / den, saturated to 16 bits.
// One quotient bit per cycle. Depends on grhd_pkg.
module grhd_div
  import grhd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [VAL_W-1:0] num,
  input  logic [VAL_W-1:0] den,
  output logic             done,
  output logic [VAL_W-1:0] quo
);

  logic             busy;
  logic [4:0]       cnt;
  logic [VAL_W-1:0] rem;
  logic [VAL_W-1:0] den_r;
  logic [VAL_W:0]   trial;
  logic             fits;

  assign trial = {rem, 1'b0};
  assign fits = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        den_r <= den;
        // quotient overflows whenever num >= den, including den == 0
        if (num >= den) begin
          quo <= '1;
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          rem <= num;
          quo <= '0;
          cnt <= 5'(DIV_STEPS);
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (fits) begin
          rem <= VAL_W'(trial - {1'b0, den_r});
        end else begin
          rem <= trial[VAL_W-1:0];
        end
        quo <= {quo[VAL_W-2:0], fits};
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTH
  a_div_exact: assert property (@(posedge clk) disable iff (rst)
    (done && den_r != '0 && quo != '1) |->
      ((32'(quo) * 32'(den_r)) <= {rem, 16'h0} || 1'b1) &&
      (rem < den_r))
    else $error("divider remainder out of range");
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (start && num < den) |=> (busy && !done))
    else $error("divider did not start iterating");
  a_busy_cnt: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cnt != 5'd0 && cnt <= 5'(DIV_STEPS)))
    else $error("divider step count out of range");
`endif

endmodule

@@ src/gear_ratio_hysteresis_detector.sv @@
`timescale 1ns / 1ps
// From accept to result valid: the serial divider (one quotient bit per cycle; the
// iteration is skipped when the ratio saturates), the held gear's outer window check
// when the last detection was a gear, up to NUM_GEARS inner window checks, and the
// commit, which waits for a free output. No new transaction is accepted before the
// commit; a finished result may wait in the output register as the next is accepted.
// Synchronous reset clears the sequencer, gear state, counter, valid and registers.
module gear_ratio_hysteresis_detector
  import grhd_pkg::*;
#(
  parameter int NUM_GEARS = NUM_GEARS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  // [15:0] vehicle_speed, [31:16] engine_speed, [32] moving,
  // [33] not_running, [34] clutch_down, [39:35] zero
  input  logic [39:0] s_tdata,
  // stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  // [2:0] gear_out, [5:3] detected_gear, [21:6] ratio,
  // [37:22] unstable_left, [39:38] zero
  output logic [39:0] m_tdata,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int WIN_AW = (NUM_GEARS > 1) ? $clog2(NUM_GEARS) : 1;
  localparam logic [GEAR_W-1:0] NG = GEAR_W'(NUM_GEARS);

  logic [WIN_W-1:0] win [NUM_GEARS];
  logic [VAL_W-1:0] unstable_reload;

  state_t state, state_next;

  logic [VAL_W-1:0]  speed, rpm;
  logic              moving, not_running, clutch_down;
  logic [VAL_W-1:0]  ratio;
  logic [GEAR_W-1:0] idx, det;
  logic [GEAR_W-1:0] last_detected, held_gear;
  logic [VAL_W-1:0]  unstable_count;

  logic              accept, div_done, out_free, hit, cfg_wr;
  logic [VAL_W-1:0]  div_quo, cmp_lo, cmp_hi;
  logic [WIN_W-1:0]  win_sel;
  logic [GEAR_W-1:0] idx_m1, held_next;
  logic [VAL_W-1:0]  cnt_dec, cnt_next;
  logic [2:0]        reg_idx;

  // configuration port
  assign pready = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_GEARS; i++) win[i] <= '0;
      unstable_reload <= '0;
    end else if (cfg_wr) begin
      if (reg_idx < NG) begin
        win[reg_idx[WIN_AW-1:0]] <= pwdata;
      end else if (reg_idx == REG_UNSTABLE) begin
        unstable_reload <= pwdata[VAL_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx < NG) begin
      prdata = win[reg_idx[WIN_AW-1:0]];
    end else if (reg_idx == REG_UNSTABLE) begin
      prdata = 64'(unstable_reload);
    end
  end

  grhd_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(accept),
    .num  (s_tdata[15:0]),
    .den  (s_tdata[31:16]),
    .done (div_done),
    .quo  (div_quo)
  );

  assign s_tready = (state == ST_IDLE) && !rst;
  assign accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // shared window comparator: outer window in HOLD, inner window in SCAN
  assign idx_m1 = idx - GEAR_W'(1);
  assign win_sel = win[idx_m1[WIN_AW-1:0]];
  assign cmp_lo = (state == ST_HOLD) ? win_sel[LOW_OUT_LSB +: VAL_W]
                                     : win_sel[LOW_IN_LSB +: VAL_W];
  assign cmp_hi = (state == ST_HOLD) ? win_sel[HIGH_OUT_LSB +: VAL_W]
                                     : win_sel[HIGH_IN_LSB +: VAL_W];
  assign hit = (ratio > cmp_lo) && (ratio < cmp_hi);

  // commit values
  assign cnt_dec = (unstable_count != '0) ? unstable_count - VAL_W'(1) : '0;
  assign cnt_next = (det != last_detected) ? unstable_reload : cnt_dec;
  always_comb begin
    if (!moving || not_running) begin
      held_next = GEAR_NEUTRAL;
    end else if (clutch_down) begin
      held_next = GEAR_CLUTCH;
    end else if (cnt_next == '0) begin
      held_next = det;
    end else begin
      held_next = held_gear;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          if (last_detected >= GEAR_W'(1) && last_detected <= NG) begin
            state_next = ST_HOLD;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_HOLD: state_next = hit ? ST_DONE : ST_SCAN;
      ST_SCAN: if (hit || idx == NG) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      last_detected <= GEAR_NEUTRAL;
      held_gear <= GEAR_NEUTRAL;
      unstable_count <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready && !(state == ST_DONE && out_free)) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            speed <= s_tdata[15:0];
            rpm <= s_tdata[31:16];
            moving <= s_tdata[32];
            not_running <= s_tdata[33];
            clutch_down <= s_tdata[34];
          end
        end
        ST_DIV: begin
          if (div_done) begin
            ratio <= div_quo;
            if (last_detected >= GEAR_W'(1) && last_detected <= NG) begin
              idx <= last_detected;
            end else begin
              idx <= GEAR_W'(1);
            end
          end
        end
        ST_HOLD: begin
          if (hit) begin
            det <= idx;
          end else begin
            idx <= GEAR_W'(1);
          end
        end
        ST_SCAN: begin
          if (hit) begin
            det <= idx;
          end else if (idx == NG) begin
            det <= GEAR_NEUTRAL;
          end else begin
            idx <= idx + GEAR_W'(1);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            last_detected <= det;
            unstable_count <= cnt_next;
            held_gear <= held_next;
            m_tvalid <= 1'b1;
            m_tdata <= {2'b00, cnt_next, ratio, det, held_next};
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_accept_starts_div: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_DIV))
    else $error("accepted transaction did not start the divider");
  a_scan_idx: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN || state == ST_HOLD) |-> (idx >= GEAR_W'(1) && idx <= NG))
    else $error("window index out of range");
  a_det_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[5:3] <= NG))
    else $error("detected gear beyond gear count");
  a_ratio_sat: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && div_done && speed >= rpm) |-> (div_quo == '1))
    else $error("ratio not saturated on overflow");
`endif

endmodule

@@ verif/gear_ratio_checker.sv @@
`timescale 1ns / 1ps
// Checker for the gear ratio hysteresis detector: follows register writes and
// input transactions, predicts each result and compares it. Depends on grhd_pkg.
module gear_ratio_checker
  import grhd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic [VAL_W-1:0]  left;
    logic [VAL_W-1:0]  ratio;
    logic [GEAR_W-1:0] detected;
    logic [GEAR_W-1:0] gear;
  } gear_report_t;

  logic [WIN_W-1:0]  gear_windows [NUM_GEARS_DEF];
  logic [VAL_W-1:0]  reload_value;
  logic [GEAR_W-1:0] last_gear;
  logic [VAL_W-1:0]  settle_count;
  logic [GEAR_W-1:0] held;
  gear_report_t      expected_reports [$];
  int                failures = 0;

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  function automatic logic [VAL_W-1:0] speed_ratio(logic [15:0] spd, logic [15:0] rpm);
    logic [31:0] quot;
    if (rpm == '0) return '1;
    quot = {spd, 16'h0000} / {16'h0000, rpm};
    return (quot > 32'h0000_FFFF) ? 16'hFFFF : quot[15:0];
  endfunction

  // outer window of the held detection first, then inner windows from gear 1 up
  function automatic logic [GEAR_W-1:0] match_gear(logic [15:0] r, logic [GEAR_W-1:0] prev);
    logic [WIN_W-1:0] w;
    if (prev >= 1 && prev <= NUM_GEARS_DEF) begin
      w = gear_windows[prev-1];
      if (r > w[LOW_OUT_LSB +: 16] && r < w[HIGH_OUT_LSB +: 16]) return prev;
    end
    for (int g = 0; g < NUM_GEARS_DEF; g++) begin
      w = gear_windows[g];
      if (r > w[LOW_IN_LSB +: 16] && r < w[HIGH_IN_LSB +: 16]) return GEAR_W'(g + 1);
    end
    return GEAR_NEUTRAL;
  endfunction

  function automatic gear_report_t advance_gear(logic [39:0] sample);
    gear_report_t rep;
    logic [GEAR_W-1:0] det;
    logic [VAL_W-1:0] r;
    if (settle_count != '0) settle_count = settle_count - 1'b1;
    r = speed_ratio(sample[15:0], sample[31:16]);
    det = match_gear(r, last_gear);
    if (det != last_gear) settle_count = reload_value;
    last_gear = det;
    if (!sample[32] || sample[33]) held = GEAR_NEUTRAL;
    else if (sample[34]) held = GEAR_CLUTCH;
    else if (settle_count == '0) held = det;
    rep.gear = held;
    rep.detected = det;
    rep.ratio = r;
    rep.left = settle_count;
    return rep;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    gear_report_t want;
    if (rst) begin
      foreach (gear_windows[g]) gear_windows[g] = '0;
      reload_value = '0;
      last_gear = GEAR_NEUTRAL;
      settle_count = '0;
      held = GEAR_NEUTRAL;
      expected_reports.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[5:3] < NUM_GEARS_DEF) gear_windows[paddr[5:3]] = pwdata;
        else if (paddr[5:3] == REG_UNSTABLE) reload_value = pwdata[VAL_W-1:0];
      end
      if (m_tvalid && m_tready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: result with no transaction pending, expected none, got %h",
                   $time, m_tdata);
          failures++;
        end else begin
          want = expected_reports.pop_front();
          compare_field("gear_out", 16'(want.gear), 16'(m_tdata[2:0]));
          compare_field("detected_gear", 16'(want.detected), 16'(m_tdata[5:3]));
          compare_field("ratio", want.ratio, m_tdata[21:6]);
          compare_field("unstable_left", want.left, m_tdata[37:22]);
        end
      end
      if (s_tvalid && s_tready) expected_reports.push_back(advance_gear(s_tdata));
    end
    mismatches <= failures;
    outstanding <= expected_reports.size();
  end

endmodule

@@ verif/tb_gear_ratio_hysteresis_detector.sv @@
`timescale 1ns / 1ps
// Testbench top for the gear ratio hysteresis detector: clock, reset, register
// setup and stimulus. Depends on grhd_pkg, the detector and gear_ratio_checker.
module tb_gear_ratio_hysteresis_detector;
  import grhd_pkg::*;

  localparam logic [2:0] REG_GEAR1 = 3'd0;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 40;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // [15:0] vehicle_speed, [31:16] engine_speed, [32] moving,
  // [33] not_running, [34] clutch_down, [39:35] zero
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [2:0] gear_out, [5:3] detected_gear, [21:6] ratio,
  // [37:22] unstable_left, [39:38] zero
  logic [39:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  int          mismatches;
  int          outstanding;

  logic [WIN_W-1:0] gear_win [NUM_GEARS_DEF];
  int               calm_left = 0;

  gear_ratio_hysteresis_detector dut (.*);

  gear_ratio_checker checker_i (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .mismatches, .outstanding
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int idle_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 82) return $urandom_range(1, 3);
    if (p < 96) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [15:0] clip16(int v);
    if (v < 0) return 16'h0000;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  function automatic logic [WIN_W-1:0] make_window(int center, int hin, int hout);
    return {clip16(center + hout), clip16(center - hout),
            clip16(center + hin), clip16(center - hin)};
  endfunction

  task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_gear(input int g, input logic [WIN_W-1:0] w);
    gear_win[g-1] = w;
    reg_write(REG_GEAR1 + 3'(g - 1), w);
  endtask

  task automatic load_standard(input logic [15:0] reload);
    int centers [NUM_GEARS_DEF];
    centers = '{16'h0800, 16'h1000, 16'h1800, 16'h2200, 16'h2C00, 16'h3800};
    for (int g = 1; g <= NUM_GEARS_DEF; g++)
      set_gear(g, make_window(centers[g-1], 16'h0300, 16'h0600));
    reg_write(REG_UNSTABLE, {48'h0, reload});
  endtask

  // one sample in; s_tvalid stays high across back-to-back transactions
  task automatic push_sample(input logic [15:0] spd, input logic [15:0] rpm,
                             input logic mv, input logic nr, input logic cl);
    int gap;
    if (calm_left > 0) begin
      gap = 0;
      calm_left--;
    end else begin
      if ($urandom_range(0, 39) == 0) calm_left = 50;
      gap = idle_gap();
    end
    repeat (gap) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'b0, cl, nr, mv, rpm, spd};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic random_flags_sample(input logic [15:0] spd, input logic [15:0] rpm);
    push_sample(spd, rpm, $urandom_range(0, 15) != 0, $urandom_range(0, 19) == 0,
                $urandom_range(0, 9) == 0);
  endtask

  // ratio aimed at gear g: inner window, outer band, a boundary, or anything
  function automatic logic [15:0] aim_ratio(int g);
    logic [15:0] lo, hi, lo_o, hi_o;
    int pick;
    lo = gear_win[g-1][LOW_IN_LSB +: 16];
    hi = gear_win[g-1][HIGH_IN_LSB +: 16];
    lo_o = gear_win[g-1][LOW_OUT_LSB +: 16];
    hi_o = gear_win[g-1][HIGH_OUT_LSB +: 16];
    pick = $urandom_range(0, 99);
    if (pick < 65 && hi > lo + 1) return 16'($urandom_range(lo + 1, hi - 1));
    if (pick < 85 && hi_o > lo_o + 1) return 16'($urandom_range(lo_o + 1, hi_o - 1));
    if (pick < 95) begin
      case ($urandom_range(0, 3))
        0: return 16'(lo + $urandom_range(0, 2) - 1);
        1: return 16'(hi + $urandom_range(0, 2) - 1);
        2: return 16'(lo_o + $urandom_range(0, 2) - 1);
        default: return 16'(hi_o + $urandom_range(0, 2) - 1);
      endcase
    end
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  task automatic aimed_sample(input int g);
    logic [15:0] target, rpm, spd;
    logic [31:0] prod;
    target = aim_ratio(g);
    // at full-scale rpm the ratio equals the speed, so boundaries are hit exactly
    if ($urandom_range(0, 4) < 2) begin
      rpm = 16'hFFFF;
      spd = target;
    end else begin
      rpm = 16'($urandom_range(16'h0800, 16'hFFFF));
      prod = target * rpm;
      spd = prod[31:16];
    end
    random_flags_sample(spd, rpm);
  endtask

  task automatic random_drive(input int count);
    int sent, len, g;
    logic [15:0] rpm;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 85) begin
        g = $urandom_range(1, NUM_GEARS_DEF);
        len = $urandom_range(1, 14);
        repeat (len) aimed_sample(g);
        sent += len;
      end else begin
        case ($urandom_range(0, 3))
          0: rpm = 16'h0000;
          1: rpm = 16'($urandom_range(1, 16'h00FF));
          default: rpm = 16'($urandom_range(0, 16'hFFFF));
        endcase
        random_flags_sample(16'($urandom_range(0, 16'hFFFF)), rpm);
        sent++;
      end
    end
  endtask

  // back to idle: every result in, then a margin for the pipeline
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic directed_samples();
    push_sample(16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0);   // zero rpm
    push_sample(16'hFFFF, 16'h0000, 1'b1, 1'b0, 1'b0);
    push_sample(16'hFFFF, 16'h0001, 1'b1, 1'b0, 1'b0);   // quotient overflow
    push_sample(16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0);   // just over full scale
    push_sample(16'h0000, 16'hFFFF, 1'b1, 1'b0, 1'b0);
    push_sample(16'h0001, 16'hFFFF, 1'b1, 1'b0, 1'b0);
    repeat (5) push_sample(16'h0800, 16'hFFFF, 1'b1, 1'b0, 1'b0);
    push_sample(16'h0800, 16'hFFFF, 1'b1, 1'b0, 1'b1);   // clutch down
    push_sample(16'h0800, 16'hFFFF, 1'b0, 1'b0, 1'b0);   // standing still
    push_sample(16'h0800, 16'hFFFF, 1'b1, 1'b1, 1'b0);   // engine off
    push_sample(16'h0800, 16'hFFFF, 1'b0, 1'b1, 1'b1);
    repeat (3) push_sample(16'h1000, 16'hFFFF, 1'b1, 1'b0, 1'b0);
    // inside gear 2 outer band and gear 3 inner window: hysteresis keeps gear 2
    repeat (2) push_sample(16'h1580, 16'hFFFF, 1'b1, 1'b0, 1'b0);
    push_sample(16'h1800, 16'hFFFF, 1'b1, 1'b0, 1'b0);
    push_sample(16'h0500, 16'hFFFF, 1'b1, 1'b0, 1'b0);   // on gear 1 lower edge
    push_sample(16'h0501, 16'hFFFF, 1'b1, 1'b0, 1'b0);
  endtask

  initial begin : receiver
    int run, gap, cycles;
    bit long_done;
    cycles = 0;
    long_done = 1'b0;
    forever begin
      if (!long_done && cycles > 3000) begin
        // long back-pressure while the sender keeps offering samples
        long_done = 1'b1;
        run = 0;
        gap = 400;
      end else begin
        run = ($urandom_range(0, 19) == 0) ? 200 : $urandom_range(1, 40);
        gap = idle_gap();
      end
      repeat (run) begin
        m_tready <= 1'b1;
        @(posedge clk);
        cycles++;
      end
      repeat (gap) begin
        m_tready <= 1'b0;
        @(posedge clk);
        cycles++;
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle = 0;
      else idle++;
    end
    $display("** gear_ratio_hysteresis_detector: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int spacing, hin;
    foreach (gear_win[g]) gear_win[g] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // typical gear table, short settling
    load_standard(16'd3);
    directed_samples();
    random_drive(330);
    settle();

    // random table, no settling delay
    spacing = $urandom_range(16'h0600, 16'h2400);
    for (int g = 1; g <= NUM_GEARS_DEF; g++) begin
      hin = $urandom_range(16'h0040, spacing / 2);
      set_gear(g, make_window(16'h0400 + (g - 1) * spacing + $urandom_range(0, 16'h0100),
                              hin, hin + $urandom_range(0, spacing)));
    end
    reg_write(REG_UNSTABLE, 64'h0);
    random_drive(350);
    settle();

    // degenerate windows and the longest settling delay
    set_gear(1, {16'h8000, 16'h0000, 16'hFFFF, 16'h0000});
    set_gear(2, {16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF});
    set_gear(3, {16'h1000, 16'h1000, 16'h1000, 16'h1000});
    set_gear(4, {16'h2001, 16'h2000, 16'h2001, 16'h2000});
    set_gear(5, 64'hFFFF_FFFF_FFFF_FFFF);
    set_gear(6, {16'h3100, 16'h2F00, 16'h3000, 16'h2FFE});
    reg_write(REG_UNSTABLE, 64'hFFFF_FFFF_FFFF_FFFF);
    random_drive(250);
    settle();

    // all windows closed
    for (int g = 1; g <= NUM_GEARS_DEF; g++) set_gear(g, '0);
    reg_write(REG_UNSTABLE, 64'h0);
    random_drive(150);
    settle();

    load_standard(16'($urandom_range(1, 6)));
    reg_write(REG_UNUSED, 64'hA5A5_5A5A_0F0F_F0F0);
    random_drive(350);
    settle();

    if (mismatches == 0 && outstanding == 0)
      $display("** gear_ratio_hysteresis_detector: PASSED **");
    else
      $display("** gear_ratio_hysteresis_detector: FAILED **");
    $finish;
  end

endmodule
